// ----- design/fdc_pkg.sv -----
// Shared types, codes and the CRC-16-CCITT byte step for the frame decoder.
// No dependencies; every other design file except fdc_queue refers to this package by scope.
package fdc_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd2;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
  localparam logic [7:0]  CAPACITY_RST    = 8'hFF;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [8:0]  MIN_FRAME = 9'd10;
  localparam logic [8:0]  HDR_END   = 9'd8;
  localparam logic [8:0]  SYNC_END  = 9'd2;

  localparam int NUM_HDR = 6;
  localparam logic [2:0] HDR_SRC     = 3'd0;
  localparam logic [2:0] HDR_DEST    = 3'd1;
  localparam logic [2:0] HDR_TYPE    = 3'd2;
  localparam logic [2:0] HDR_SUBTYPE = 3'd3;
  localparam logic [2:0] HDR_SEQ     = 3'd4;
  localparam logic [2:0] HDR_LEN     = 3'd5;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_SYNC  = 3'd2,
    ST_BAD_CRC   = 3'd3,
    ST_TOO_LARGE = 3'd4
  } status_t;

  typedef logic [NUM_HDR-1:0][7:0] hdr_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] capacity;
  } cfg_t;

  typedef struct packed {
    logic       has_pl;
    logic [7:0] pl_byte;
    logic       has_vd;
    status_t    status;
    hdr_t       hdr;
  } entry_t;

  typedef struct packed {
    logic       is_verdict;
    logic [7:0] payload_byte;
    status_t    status;
    hdr_t       hdr;
  } out_item_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- design/fdc_front.sv -----
// Front end: frame parser with sync check, header capture and CRC-16 per byte.
// Uses fdc_pkg; feeds one entry per productive byte into the decoupling queue.
module fdc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  fdc_pkg::cfg_t   cfg,
  input  logic            push,
  input  logic [7:0]      rx_byte,
  input  logic            end_of_buffer,
  input  logic            q_full,
  output logic            q_push,
  output fdc_pkg::entry_t q_entry
);

  logic [8:0]    pos_r, pos_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic          sync_ok_r, sync_ok_nxt;
  fdc_pkg::hdr_t hdr_r, hdr_nxt;
  logic [7:0]    crc_hi_r, crc_hi_nxt;
  logic          done_r, done_nxt;

  logic          accept;
  logic [8:0]    crc_at;
  logic [2:0]    hdr_idx;
  logic [15:0]   got_crc;
  fdc_pkg::entry_t ent;

  assign accept  = push & ~q_full;
  assign crc_at  = fdc_pkg::HDR_END + {1'b0, hdr_r[fdc_pkg::HDR_LEN]};
  assign hdr_idx = 3'(pos_r - fdc_pkg::SYNC_END);
  assign got_crc = {crc_hi_r, rx_byte};

  always_comb begin
    pos_nxt     = pos_r;
    crc_nxt     = crc_r;
    sync_ok_nxt = sync_ok_r;
    hdr_nxt     = hdr_r;
    crc_hi_nxt  = crc_hi_r;
    done_nxt    = done_r;
    ent         = '0;
    ent.status  = fdc_pkg::ST_OK;
    if (!done_r) begin
      if (pos_r < fdc_pkg::SYNC_END) begin
        if (rx_byte != (pos_r[0] ? cfg.sync_second : cfg.sync_first)) begin
          sync_ok_nxt = 1'b0;
        end
        crc_nxt = fdc_pkg::crc16_byte(crc_r, rx_byte);
      end else if (pos_r < fdc_pkg::HDR_END) begin
        hdr_nxt[hdr_idx] = rx_byte;
        crc_nxt = fdc_pkg::crc16_byte(crc_r, rx_byte);
      end else if (pos_r < crc_at) begin
        crc_nxt     = fdc_pkg::crc16_byte(crc_r, rx_byte);
        ent.has_pl  = 1'b1;
        ent.pl_byte = rx_byte;
      end else if (pos_r == crc_at) begin
        crc_hi_nxt = rx_byte;
      end else begin
        ent.has_vd = 1'b1;
        if (!sync_ok_r) begin
          ent.status = fdc_pkg::ST_BAD_SYNC;
        end else if (got_crc != crc_r) begin
          ent.status = fdc_pkg::ST_BAD_CRC;
        end else if (hdr_r[fdc_pkg::HDR_LEN] > cfg.capacity) begin
          ent.status = fdc_pkg::ST_TOO_LARGE;
        end else begin
          ent.status = fdc_pkg::ST_OK;
        end
        done_nxt = 1'b1;
      end
      pos_nxt = pos_r + 9'd1;
    end
    if (end_of_buffer) begin
      if (!done_nxt) begin
        ent.has_vd = 1'b1;
        if (pos_nxt < fdc_pkg::MIN_FRAME) begin
          ent.status = fdc_pkg::ST_SHORT;
        end else if (!sync_ok_nxt) begin
          ent.status = fdc_pkg::ST_BAD_SYNC;
        end else begin
          ent.status = fdc_pkg::ST_SHORT;
        end
      end
      pos_nxt     = '0;
      crc_nxt     = fdc_pkg::CRC_INIT;
      sync_ok_nxt = 1'b1;
      crc_hi_nxt  = '0;
      done_nxt    = 1'b0;
    end
    ent.hdr = ent.has_vd ? hdr_nxt : '0;
    if (end_of_buffer) begin
      hdr_nxt = '0;
    end
  end

  assign q_push  = accept & (ent.has_pl | ent.has_vd);
  assign q_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      crc_r     <= fdc_pkg::CRC_INIT;
      sync_ok_r <= 1'b1;
      hdr_r     <= '0;
      crc_hi_r  <= '0;
      done_r    <= 1'b0;
    end else if (accept) begin
      pos_r     <= pos_nxt;
      crc_r     <= crc_nxt;
      sync_ok_r <= sync_ok_nxt;
      hdr_r     <= hdr_nxt;
      crc_hi_r  <= crc_hi_nxt;
      done_r    <= done_nxt;
    end
  end

endmodule

// ----- design/fdc_queue.sv -----
// Small register queue that decouples the parser from the result stage.
// No package dependency; width and depth come from parameters.
module fdc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             q_full,
  output logic             q_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign q_full  = (cnt_r == CNT_W'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en & ~q_full;
  assign do_rd   = rd_en & ~q_empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- design/fdc_back.sv -----
// Result stage: splits each queued entry into payload and verdict beats.
// Uses fdc_pkg; holds the output register that faces the result channel.
module fdc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  fdc_pkg::entry_t    q_entry,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output fdc_pkg::out_item_t item
);

  logic               valid_r, valid_nxt;
  logic               pl_sent_r, pl_sent_nxt;
  fdc_pkg::out_item_t item_r, item_nxt;
  logic               load_ok;

  assign load_ok = ~valid_r | pop;

  always_comb begin
    valid_nxt   = valid_r;
    pl_sent_nxt = pl_sent_r;
    item_nxt    = item_r;
    q_pop       = 1'b0;
    if (load_ok) begin
      valid_nxt = 1'b0;
      if (!q_empty) begin
        valid_nxt = 1'b1;
        item_nxt  = '0;
        if (q_entry.has_pl && !pl_sent_r) begin
          item_nxt.payload_byte = q_entry.pl_byte;
          item_nxt.status       = fdc_pkg::ST_OK;
          if (q_entry.has_vd) begin
            pl_sent_nxt = 1'b1;
          end else begin
            q_pop = 1'b1;
          end
        end else begin
          item_nxt.is_verdict = 1'b1;
          item_nxt.status     = q_entry.status;
          item_nxt.hdr        = q_entry.hdr;
          pl_sent_nxt         = 1'b0;
          q_pop               = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      pl_sent_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      pl_sent_r <= pl_sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign empty = ~valid_r;
  assign item  = item_r;

endmodule

// ----- design/frame_decoder_crc16_check_unit.sv -----
// Top level of the sync-header frame decoder with CRC-16-CCITT check.
// Uses fdc_pkg, fdc_front, fdc_queue and fdc_back.
//
// The decoder takes one received byte per beat on the push side while full
// is low, the last byte of a buffer flagged by end_of_buffer: the CRC step,
// sync check and header capture for a byte are done in the cycle it is
// accepted. Each byte yields no beat, a payload beat, a verdict beat, or a
// payload beat followed by a verdict beat; the result side sends one beat
// per cycle from its output register while pop is high, so a byte that
// yields two beats holds its queue entry longer, absorbed by the
// QUEUE_DEPTH-entry queue between parser and result stage. Results pass
// through the queue and then the output register. Configuration writes are
// always ready; writes to unknown indexes are dropped.
module frame_decoder_crc16_check_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_rx_byte,
  input  logic       in_end_of_buffer,
  output logic       empty,
  input  logic       pop,
  output logic       out_is_verdict,
  output logic [7:0] out_payload_byte,
  output logic [2:0] out_status,
  output logic [7:0] out_source_id,
  output logic [7:0] out_dest_id,
  output logic [7:0] out_message_type,
  output logic [7:0] out_message_subtype,
  output logic [7:0] out_sequence_res,
  output logic [7:0] out_payload_length
);

  fdc_pkg::cfg_t      cfg_r;
  fdc_pkg::entry_t    front_entry, head_entry;
  fdc_pkg::out_item_t item;
  logic               q_push, q_pop, q_full, q_empty;
  logic [$bits(fdc_pkg::entry_t)-1:0] head_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= fdc_pkg::SYNC_FIRST_RST;
      cfg_r.sync_second <= fdc_pkg::SYNC_SECOND_RST;
      cfg_r.capacity    <= fdc_pkg::CAPACITY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        fdc_pkg::CFG_SYNC_FIRST:  cfg_r.sync_first  <= cfg_data;
        fdc_pkg::CFG_SYNC_SECOND: cfg_r.sync_second <= cfg_data;
        fdc_pkg::CFG_CAPACITY:    cfg_r.capacity    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fdc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .push          (push),
    .rx_byte       (in_rx_byte),
    .end_of_buffer (in_end_of_buffer),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (front_entry)
  );

  fdc_queue #(
    .WIDTH ($bits(fdc_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (front_entry),
    .rd_en   (q_pop),
    .rd_data (head_bits),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  assign head_entry = fdc_pkg::entry_t'(head_bits);

  fdc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_entry (head_entry),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .item    (item)
  );

  assign full                = q_full;
  assign out_is_verdict      = item.is_verdict;
  assign out_payload_byte    = item.payload_byte;
  assign out_status          = item.status;
  assign out_source_id       = item.hdr[fdc_pkg::HDR_SRC];
  assign out_dest_id         = item.hdr[fdc_pkg::HDR_DEST];
  assign out_message_type    = item.hdr[fdc_pkg::HDR_TYPE];
  assign out_message_subtype = item.hdr[fdc_pkg::HDR_SUBTYPE];
  assign out_sequence_res    = item.hdr[fdc_pkg::HDR_SEQ];
  assign out_payload_length  = item.hdr[fdc_pkg::HDR_LEN];

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue reports full and empty at once");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_is_verdict) |->
      (out_status == fdc_pkg::ST_OK && out_source_id == 8'd0 &&
       out_payload_length == 8'd0))
    else $error("payload beat carries verdict fields");

  a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_is_verdict) |->
      (out_payload_byte == 8'd0 && out_status <= fdc_pkg::ST_TOO_LARGE))
    else $error("verdict beat malformed");

  a_split_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_is_verdict && head_entry.has_vd && !q_empty &&
     !$past(q_empty) && !$past(q_pop)) |=> (!empty))
    else $error("verdict of a split entry lost");

endmodule
